[src/chd_pkg.sv]
// chd_pkg: shared types and constants of the canonical Huffman decoder.
// No dependencies.
`timescale 1ns / 1ps

package chd_pkg;

    localparam int MODE_W      = 2;
    localparam int SYM_FIELD_W = 9;
    localparam int LEN_FIELD_W = 4;
    localparam int BITS_W      = 5;
    localparam int CODE_W      = 16;
    localparam int KIND_W      = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_BUILD = 2'd2,
        MODE_BIT   = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYMBOL   = 2'd0,
        KIND_NO_MATCH = 2'd1,
        KIND_BUILD_OK = 2'd2,
        KIND_BUILD_OV = 2'd3
    } t_kind;

endpackage

[src/chd_length_store.sv]
// chd_length_store: per-symbol code length memory, one write and one
// registered read per cycle. Depends on chd_pkg.
`timescale 1ns / 1ps

module chd_length_store #(
    parameter int DEPTH = 288,
    parameter int AW    = 9
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [chd_pkg::LEN_FIELD_W-1:0] i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [chd_pkg::LEN_FIELD_W-1:0] o_rdata
);

    logic [chd_pkg::LEN_FIELD_W-1:0] r_mem [DEPTH];
    logic [chd_pkg::LEN_FIELD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/chd_sorted_table.sv]
// chd_sorted_table: symbols ordered by code length then index, filled by
// the build pass and read by decode. Depends on chd_pkg.
`timescale 1ns / 1ps

module chd_sorted_table #(
    parameter int DEPTH = 288,
    parameter int AW    = 9
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [chd_pkg::SYM_FIELD_W-1:0] i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [chd_pkg::SYM_FIELD_W-1:0] o_rdata
);

    logic [chd_pkg::SYM_FIELD_W-1:0] r_mem [DEPTH];
    logic [chd_pkg::SYM_FIELD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/canonical_huffman_decoder.sv]
// canonical_huffman_decoder: top level, command sequencer, build passes and
// bit decoder. Depends on chd_pkg, chd_length_store, chd_sorted_table.
//
// Loads per-symbol code lengths, builds a canonical (deflate style) code and
// decodes one stream bit per beat, MSB of a code first. A decode bit that
// matches passes through the S_DEC state, since the symbol comes from the
// sorted-symbol memory, whose read port is registered. A build runs a count
// pass and a sort pass, each walking the length memory once, one symbol per
// cycle, and between them the S_CODES state steps through the code lengths.
// A clear, and reset, run a sweep that zeroes the length memory; no beat is
// accepted during it. A finished result waits in an output register; no new
// beat is taken until that result leaves, at the earliest in the same cycle.
`timescale 1ns / 1ps

module canonical_huffman_decoder #(
    parameter int MAX_SYMBOLS  = 288,
    parameter int MAX_LEN      = 15,
    parameter int DECODE_LIMIT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [chd_pkg::MODE_W-1:0]      i_mode,
    input  logic [chd_pkg::SYM_FIELD_W-1:0] i_symbol_index,
    input  logic [chd_pkg::LEN_FIELD_W-1:0] i_code_length,
    input  logic                            i_bit_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [chd_pkg::KIND_W-1:0]      o_kind,
    output logic [chd_pkg::SYM_FIELD_W-1:0] o_symbol,
    output logic [chd_pkg::BITS_W-1:0]      o_bits_used
);

    localparam int SYM_W  = $clog2(MAX_SYMBOLS);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int LEN_IW = $clog2(MAX_LEN + 1);
    localparam int NLEN   = MAX_LEN + 1;
    localparam int CW     = chd_pkg::CODE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_CNT, S_CODES, S_SORT, S_DEC
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]  r_s;      // walk counter
    logic              r_pv;     // read data pending from length memory
    logic [SYM_W-1:0]  r_ps;     // symbol of the pending read
    logic [LEN_IW-1:0] r_len;
    logic [CW-1:0]     r_code;
    logic [CNT_W-1:0]  r_idx;
    logic [17:0]       r_left;
    logic              r_over;

    logic [CNT_W-1:0]  r_counts   [NLEN];
    logic [CW-1:0]     r_first    [NLEN];
    logic [CNT_W-1:0]  r_findex   [NLEN];
    logic [CNT_W-1:0]  r_place    [NLEN];

    logic [CW-1:0]     r_acc;
    logic [chd_pkg::BITS_W-1:0] r_bc;

    logic              r_dec_ok;
    logic [chd_pkg::BITS_W-1:0] r_dec_len;

    logic              r_out_valid;
    logic [chd_pkg::KIND_W-1:0]      r_kind;
    logic [chd_pkg::SYM_FIELD_W-1:0] r_sym;
    logic [chd_pkg::BITS_W-1:0]      r_bits;

    // memory ports
    logic                            len_we;
    logic [SYM_W-1:0]                len_waddr;
    logic [chd_pkg::LEN_FIELD_W-1:0] len_wdata;
    logic [SYM_W-1:0]                len_raddr;
    logic [chd_pkg::LEN_FIELD_W-1:0] len_rdata;
    logic                            srt_we;
    logic [SYM_W-1:0]                srt_waddr;
    logic [SYM_W-1:0]                srt_raddr;
    logic [chd_pkg::SYM_FIELD_W-1:0] srt_rdata;

    logic accept;
    logic out_free;
    logic res_set;
    chd_pkg::t_mode mode;

    // length read back during a walk
    logic              pend_used;
    logic [LEN_IW-1:0] pend_l;

    // code length table step
    logic [CNT_W-1:0]  cnt_prev;
    logic [CNT_W-1:0]  cnt_cur;
    logic [CW-1:0]     code_sum;
    logic [CW-1:0]     n_code;
    logic [19:0]       n_left;

    // decode step
    logic [CW-1:0]     n_acc;
    logic [chd_pkg::BITS_W-1:0] n_bc;
    logic              in_len;
    logic [LEN_IW-1:0] d_idx;
    logic [CW-1:0]     d_first;
    logic [CW-1:0]     d_diff;
    logic              d_hit;
    logic [CW:0]       d_p;
    logic              d_p_ok;

    assign mode     = chd_pkg::t_mode'(i_mode);
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept   = i_in_valid && o_in_ready;

    assign pend_used = (len_rdata != '0) && (32'(len_rdata) <= MAX_LEN);
    assign pend_l    = pend_used ? LEN_IW'(len_rdata) : '0;

    assign cnt_prev = r_counts[r_len - 1'b1];
    assign cnt_cur  = r_counts[r_len];
    assign code_sum = r_code + CW'(cnt_prev);
    assign n_code   = {code_sum[CW-2:0], 1'b0};
    assign n_left   = {1'b0, r_left, 1'b0} - 20'(cnt_cur);

    assign n_acc   = {r_acc[CW-2:0], i_bit_in};
    assign n_bc    = r_bc + 1'b1;
    assign in_len  = 32'(n_bc) <= MAX_LEN;
    assign d_idx   = in_len ? LEN_IW'(n_bc) : '0;
    assign d_first = r_first[d_idx];
    assign d_diff  = n_acc - d_first;
    assign d_hit   = in_len && (n_acc >= d_first) && (d_diff < CW'(r_counts[d_idx]));
    assign d_p     = (CW+1)'(r_findex[d_idx]) + (CW+1)'(d_diff);
    assign d_p_ok  = 32'(d_p) < MAX_SYMBOLS;

    // a result enters the output register this cycle
    assign res_set = (r_state == S_DEC)
                     || ((r_state == S_SORT) && (32'(r_s) == MAX_SYMBOLS) && !r_pv)
                     || (accept && mode == chd_pkg::MODE_BIT && !d_hit
                         && (32'(n_bc) >= DECODE_LIMIT));

    always_comb begin
        len_we    = 1'b0;
        len_waddr = SYM_W'(i_symbol_index);
        len_wdata = i_code_length;
        if (r_state == S_CLEAR) begin
            len_we    = 1'b1;
            len_waddr = r_s[SYM_W-1:0];
            len_wdata = '0;
        end else if (accept && mode == chd_pkg::MODE_LOAD
                     && 32'(i_symbol_index) < MAX_SYMBOLS) begin
            len_we = 1'b1;
        end
    end

    assign len_raddr = r_s[SYM_W-1:0];

    assign srt_we    = (r_state == S_SORT) && r_pv && pend_used
                       && (32'(r_place[pend_l]) < MAX_SYMBOLS);
    assign srt_waddr = r_place[pend_l][SYM_W-1:0];
    assign srt_raddr = d_p[SYM_W-1:0];

    chd_length_store #(.DEPTH(MAX_SYMBOLS), .AW(SYM_W)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    chd_sorted_table #(.DEPTH(MAX_SYMBOLS), .AW(SYM_W)) u_srt (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (chd_pkg::SYM_FIELD_W'(r_ps)),
        .i_raddr (srt_raddr),
        .o_rdata (srt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_s         <= '0;
            r_pv        <= 1'b0;
            r_acc       <= '0;
            r_bc        <= '0;
            r_out_valid <= 1'b0;
            r_over      <= 1'b0;
            for (int i = 0; i < NLEN; i++) begin
                r_counts[i] <= '0;
                r_first[i]  <= '0;
                r_findex[i] <= '0;
            end
        end else begin
            if (res_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (mode)
                            chd_pkg::MODE_CLEAR: begin
                                for (int i = 0; i < NLEN; i++) begin
                                    r_counts[i] <= '0;
                                end
                                r_acc   <= '0;
                                r_bc    <= '0;
                                r_s     <= '0;
                                r_state <= S_CLEAR;
                            end
                            chd_pkg::MODE_LOAD: begin
                            end
                            chd_pkg::MODE_BUILD: begin
                                for (int i = 0; i < NLEN; i++) begin
                                    r_counts[i] <= '0;
                                end
                                r_first[0]  <= '0;
                                r_findex[0] <= '0;
                                r_s     <= '0;
                                r_pv    <= 1'b0;
                                r_code  <= '0;
                                r_idx   <= '0;
                                r_left  <= 18'd1;
                                r_over  <= 1'b0;
                                r_state <= S_CNT;
                            end
                            chd_pkg::MODE_BIT: begin
                                if (d_hit) begin
                                    r_dec_ok  <= d_p_ok;
                                    r_dec_len <= n_bc;
                                    r_acc     <= '0;
                                    r_bc      <= '0;
                                    r_state   <= S_DEC;
                                end else if (32'(n_bc) >= DECODE_LIMIT) begin
                                    r_kind      <= chd_pkg::KIND_NO_MATCH;
                                    r_sym       <= '0;
                                    r_bits      <= n_bc;
                                    r_acc       <= '0;
                                    r_bc        <= '0;
                                end else begin
                                    r_acc <= n_acc;
                                    r_bc  <= n_bc;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (32'(r_s) == MAX_SYMBOLS - 1) begin
                        r_state <= S_IDLE;
                    end
                    r_s <= r_s + 1'b1;
                end
                S_CNT, S_SORT: begin
                    if (32'(r_s) < MAX_SYMBOLS) begin
                        r_s  <= r_s + 1'b1;
                        r_ps <= r_s[SYM_W-1:0];
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && pend_used) begin
                        if (r_state == S_CNT) begin
                            r_counts[pend_l] <= r_counts[pend_l] + 1'b1;
                        end else begin
                            r_place[pend_l] <= r_place[pend_l] + 1'b1;
                        end
                    end
                    if (32'(r_s) == MAX_SYMBOLS && !r_pv) begin
                        if (r_state == S_CNT) begin
                            r_len   <= LEN_IW'(1);
                            r_state <= S_CODES;
                        end else begin
                            r_kind      <= r_over ? chd_pkg::KIND_BUILD_OV
                                                  : chd_pkg::KIND_BUILD_OK;
                            r_sym       <= '0;
                            r_bits      <= '0;
                            r_acc       <= '0;
                            r_bc        <= '0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                S_CODES: begin
                    r_first[r_len]  <= n_code;
                    r_findex[r_len] <= r_idx;
                    r_place[r_len]  <= r_idx;
                    r_code          <= n_code;
                    r_idx           <= r_idx + cnt_cur;
                    // once negative only the flag matters
                    if (n_left[19]) begin
                        r_over <= 1'b1;
                        r_left <= '0;
                    end else if (n_left > 20'd65536) begin
                        r_left <= 18'd65536;
                    end else begin
                        r_left <= n_left[17:0];
                    end
                    if (32'(r_len) == MAX_LEN) begin
                        r_s     <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_SORT;
                    end else begin
                        r_len <= r_len + 1'b1;
                    end
                end
                S_DEC: begin
                    r_kind      <= chd_pkg::KIND_SYMBOL;
                    r_sym       <= r_dec_ok ? srt_rdata : '0;
                    r_bits      <= r_dec_len;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_symbol    = r_sym;
    assign o_bits_used = r_bits;

    // a matching bit shows its symbol after the S_DEC state has loaded the output register
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && mode == chd_pkg::MODE_BIT && d_hit)
        |=> ##1 (o_out_valid && o_kind == chd_pkg::KIND_SYMBOL))
        else $error("decode hit did not produce a symbol");

    // the partial code never reaches the decode limit between beats
    a_bc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_bc) < DECODE_LIMIT))
        else $error("bit counter beyond limit");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CODES) |-> (r_left <= 18'd65536))
        else $error("code space tally out of range");

endmodule
